// File: rtl/core/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement: shared types and constants
// Sequencer state codes, scan status flags and the fixed field widths.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int CFG_W      = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int STAMP_W    = 32;
    localparam int COUNT_W    = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } seq_state_t;

    typedef struct packed {
        logic hit;
        logic empty;
    } scan_flags_t;

endpackage

// File: rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement
// Timestamp based least-recently-used replacement over a set of page frames.
// ----------------------------------------------------------------------------
// A page reference is taken when start is high and busy is low. The block
// then reads the active frames one per cycle from its frame store through a
// single compare unit, which finds a hit, the first empty frame and the
// oldest stamp. The update state then writes the chosen frame, after which
// the result beat appears on fault, frame_slot, evicted_valid, evicted_page
// and fault_total for exactly one cycle with done high. A new reference is
// not taken before the previous one has reached its result beat. busy is
// low in the cycle that carries the result beat. The receiver cannot stall
// the block. cfg_write with cfg_data sets the number of active frames; the
// user writes it between references only, which the block does not enforce.
// Reset empties every frame, clears the use clock and the fault count, sets
// the active frame count to sixteen and needs no clearing pass.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  start,
    input  logic [PAGE_BITS-1:0]  page,
    output logic                  busy,
    output logic                  done,
    output logic                  fault,
    output logic [SLOT_OUT_W-1:0] frame_slot,
    output logic                  evicted_valid,
    output logic [PAGE_BITS-1:0]  evicted_page,
    output logic [COUNT_W-1:0]    fault_total
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int N_W    = $clog2(FRAMES + 1);
    localparam int DATA_W = PAGE_BITS + STAMP_W;

    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [N_W-1:0]       n_active;
    logic [N_W-1:0]       n_reg;
    logic [N_W-1:0]       iss_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [FRAMES-1:0]    slot_valid_reg;
    logic [STAMP_W-1:0]   use_clock_reg;
    logic [STAMP_W-1:0]   use_clock_next;
    logic [COUNT_W-1:0]   fault_count_reg;
    logic                 accept;
    logic                 rd_en;
    logic                 wr_en;
    logic [DATA_W-1:0]    rd_data;
    scan_flags_t          flags;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     empty_idx;
    logic [IDX_W-1:0]     min_idx;
    logic [PAGE_BITS-1:0] min_page;
    logic [IDX_W-1:0]     slot_sel;
    logic                 done_reg;
    logic                 fault_reg;
    logic [SLOT_OUT_W-1:0] slot_out_reg;
    logic                 ev_valid_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;

    assign accept = start && (state_reg == ST_IDLE);
    assign rd_en  = (state_reg == ST_SCAN) && (iss_reg != n_reg);
    assign wr_en  = (state_reg == ST_UPDATE);

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_active = N_W'(1);
        end
        else if (32'(cfg_reg) > 32'(FRAMES))
        begin
            n_active = N_W'(FRAMES);
        end
        else
        begin
            n_active = N_W'(cfg_reg);
        end
    end

    always_comb
    begin
        if (flags.hit)
        begin
            slot_sel = hit_idx;
        end
        else if (flags.empty)
        begin
            slot_sel = empty_idx;
        end
        else
        begin
            slot_sel = min_idx;
        end
    end

    assign use_clock_next = use_clock_reg + STAMP_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((iss_reg == n_reg) && !pend_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cfg_reg         <= CFG_RESET;
            iss_reg         <= '0;
            pend_reg        <= 1'b0;
            slot_valid_reg  <= '0;
            use_clock_reg   <= '0;
            fault_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
            done_reg  <= wr_en;
            if (cfg_write)
            begin
                cfg_reg <= cfg_data;
            end
            if (accept)
            begin
                iss_reg <= '0;
            end
            else if (rd_en)
            begin
                iss_reg <= iss_reg + N_W'(1);
            end
            if (wr_en)
            begin
                slot_valid_reg[slot_sel] <= 1'b1;
                use_clock_reg            <= use_clock_next;
                if (!flags.hit && (fault_count_reg != COUNT_MAX))
                begin
                    fault_count_reg <= fault_count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page;
            n_reg    <= n_active;
        end
        cmp_idx_reg <= iss_reg[IDX_W-1:0];
        if (wr_en)
        begin
            fault_reg    <= !flags.hit;
            slot_out_reg <= SLOT_OUT_W'(slot_sel);
            ev_valid_reg <= !flags.hit && !flags.empty;
            ev_page_reg  <= (!flags.hit && !flags.empty) ? min_page : '0;
        end
    end

    lrupr_frame_mem #(
        .DEPTH  (FRAMES),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_sel),
        .wr_data ({page_reg, use_clock_next}),
        .rd_en   (rd_en),
        .rd_addr (iss_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    lrupr_scan_unit #(
        .IDX_W     (IDX_W),
        .PAGE_BITS (PAGE_BITS)
    ) u_scan_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept),
        .en          (pend_reg),
        .idx         (cmp_idx_reg),
        .entry_valid (slot_valid_reg[cmp_idx_reg]),
        .entry_page  (rd_data[DATA_W-1:STAMP_W]),
        .entry_stamp (rd_data[STAMP_W-1:0]),
        .ref_page    (page_reg),
        .flags       (flags),
        .hit_idx     (hit_idx),
        .empty_idx   (empty_idx),
        .min_idx     (min_idx),
        .min_page    (min_page)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign fault         = fault_reg;
    assign frame_slot    = slot_out_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = fault_count_reg;

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result beat lasted more than one cycle.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result beat appeared while a reference was in progress.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted reference did not start a scan.");

    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted_valid) |-> fault)
        else $error("Eviction reported on a hit.");

    a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> ((iss_reg == n_reg) && !pend_reg))
        else $error("Frame written before the scan finished.");
`endif

endmodule

// File: rtl/core/lrupr_frame_mem.sv
// ----------------------------------------------------------------------------
// LRU page replacement: frame store
// One write port and one registered read port holding page and stamp per frame.
// ----------------------------------------------------------------------------
module lrupr_frame_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/lrupr_scan_unit.sv
// ----------------------------------------------------------------------------
// LRU page replacement: scan unit
// Looks at one frame per cycle while en is high and keeps the first hit, the
// first empty frame and the frame with the smallest stamp.
// ----------------------------------------------------------------------------
module lrupr_scan_unit
    import lrupr_pkg::*;
#(
    parameter int IDX_W     = 4,
    parameter int PAGE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 en,
    input  logic [IDX_W-1:0]     idx,
    input  logic                 entry_valid,
    input  logic [PAGE_BITS-1:0] entry_page,
    input  logic [STAMP_W-1:0]   entry_stamp,
    input  logic [PAGE_BITS-1:0] ref_page,
    output scan_flags_t          flags,
    output logic [IDX_W-1:0]     hit_idx,
    output logic [IDX_W-1:0]     empty_idx,
    output logic [IDX_W-1:0]     min_idx,
    output logic [PAGE_BITS-1:0] min_page
);

    scan_flags_t          flags_reg;
    scan_flags_t          flags_next;
    logic                 first_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     empty_idx_reg;
    logic [IDX_W-1:0]     min_idx_reg;
    logic [PAGE_BITS-1:0] min_page_reg;
    logic [STAMP_W-1:0]   min_stamp_reg;
    logic                 take_hit;
    logic                 take_empty;
    logic                 take_min;

    assign take_hit   = en && entry_valid && (entry_page == ref_page) && !flags_reg.hit;
    assign take_empty = en && !entry_valid && !flags_reg.empty;
    assign take_min   = en && (first_reg || (entry_stamp < min_stamp_reg));

    always_comb
    begin
        flags_next = flags_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else
        begin
            if (take_hit)
            begin
                flags_next.hit = 1'b1;
            end
            if (take_empty)
            begin
                flags_next.empty = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            flags_reg <= flags_next;
            if (clear)
            begin
                first_reg <= 1'b1;
            end
            else if (en)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_hit)
        begin
            hit_idx_reg <= idx;
        end
        if (take_empty)
        begin
            empty_idx_reg <= idx;
        end
        if (take_min)
        begin
            min_idx_reg   <= idx;
            min_page_reg  <= entry_page;
            min_stamp_reg <= entry_stamp;
        end
    end

    assign flags     = flags_reg;
    assign hit_idx   = hit_idx_reg;
    assign empty_idx = empty_idx_reg;
    assign min_idx   = min_idx_reg;
    assign min_page  = min_page_reg;

endmodule

// File: tb/lru_page_replacement_tb.sv
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page references and frame count writes into the block, predicts
// every result beat with a cycle-free model of the timestamp LRU scheme and
// compares each beat field by field. A short directed sequence covers hits,
// fills, evictions and the odd frame counts, then random phases follow.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
    import lrupr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;

    typedef enum logic [1:0] {
        STIM_REF,
        STIM_CFG,
        STIM_DRAIN
    } stim_kind_t;

    typedef struct {
        stim_kind_t           kind;
        logic [PAGE_BITS-1:0] page;
        logic [CFG_W-1:0]     frames;
        int                   gap;
    } stim_t;

    typedef struct packed {
        logic                  fault;
        logic [SLOT_OUT_W-1:0] frame_slot;
        logic                  evicted_valid;
        logic [PAGE_BITS-1:0]  evicted_page;
        logic [COUNT_W-1:0]    fault_total;
    } lru_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  start = 1'b0;
    logic [PAGE_BITS-1:0]  page = '0;
    logic                  busy;
    logic                  done;
    logic                  fault;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_W-1:0]    fault_total;

    stim_t        pending_stim[$];
    lru_outcome_t expected_outcomes[$];
    logic         ref_taken = 1'b0;
    int           gap_left = -1;
    int           failures = 0;

    logic [CFG_W-1:0]     use_frames;
    logic                 frame_valid[FRAMES];
    logic [PAGE_BITS-1:0] frame_page[FRAMES];
    logic [STAMP_W-1:0]   frame_stamp[FRAMES];
    logic [STAMP_W-1:0]   use_clock;
    logic [COUNT_W-1:0]   fault_count;

    lru_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .start         (start),
        .page          (page),
        .busy          (busy),
        .done          (done),
        .fault         (fault),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int active_frames(input logic [CFG_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > FRAMES)
            return FRAMES;
        return int'(setting);
    endfunction

    function automatic lru_outcome_t lru_reference(input logic [PAGE_BITS-1:0] pg);
        lru_outcome_t       res;
        int                 n;
        int                 slot;
        bit                 hit;
        bit                 empty_found;
        logic [STAMP_W-1:0] oldest;

        n = active_frames(use_frames);
        slot = 0;
        hit = 1'b0;
        empty_found = 1'b0;
        res = '0;
        for (int i = 0; i < n; i++)
        begin
            if (!hit && frame_valid[i] && frame_page[i] == pg)
            begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (!hit)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (!empty_found && !frame_valid[i])
                begin
                    empty_found = 1'b1;
                    slot = i;
                end
            end
            if (!empty_found)
            begin
                oldest = frame_stamp[0];
                slot = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (frame_stamp[i] < oldest)
                    begin
                        oldest = frame_stamp[i];
                        slot = i;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page = frame_page[slot];
            end
            if (fault_count != COUNT_MAX)
                fault_count++;
            frame_valid[slot] = 1'b1;
            frame_page[slot] = pg;
        end
        use_clock++;
        frame_stamp[slot] = use_clock;
        res.fault = !hit;
        res.frame_slot = slot[SLOT_OUT_W-1:0];
        res.fault_total = fault_count;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lru_outcome_t want;

        if (!rst_n)
        begin
            ref_taken <= 1'b0;
            use_frames = CFG_RESET;
            use_clock = '0;
            fault_count = '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_valid[i] = 1'b0;
                frame_page[i] = '0;
                frame_stamp[i] = '0;
            end
        end
        else
        begin
            ref_taken <= start && !busy;
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result beat arrived with no reference outstanding");
                    failures++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("fault", 32'(want.fault), 32'(fault));
                    check_field("frame_slot", 32'(want.frame_slot), 32'(frame_slot));
                    check_field("evicted_valid", 32'(want.evicted_valid),
                                32'(evicted_valid));
                    check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
                    check_field("fault_total", want.fault_total, fault_total);
                end
            end
            if (cfg_write)
                use_frames = cfg_data;
            if (start && !busy)
                expected_outcomes.push_back(lru_reference(page));
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        logic                 nx_start;
        logic [PAGE_BITS-1:0] nx_page;
        logic                 nx_cfg_write;
        logic [CFG_W-1:0]     nx_cfg_data;
        stim_t                head;

        if (!rst_n)
        begin
            start <= 1'b0;
            page <= '0;
            cfg_write <= 1'b0;
            cfg_data <= '0;
            gap_left = -1;
        end
        else
        begin
            nx_start = start && !ref_taken;
            nx_page = page;
            nx_cfg_write = 1'b0;
            nx_cfg_data = cfg_data;
            if (!nx_start && pending_stim.size() != 0)
            begin
                head = pending_stim[0];
                case (head.kind)
                    STIM_REF:
                    begin
                        if (gap_left < 0)
                            gap_left = head.gap;
                        if (gap_left > 0)
                            gap_left--;
                        else
                        begin
                            nx_start = 1'b1;
                            nx_page = head.page;
                            void'(pending_stim.pop_front());
                            gap_left = -1;
                        end
                    end
                    STIM_CFG:
                    begin
                        if (!start && expected_outcomes.size() == 0)
                        begin
                            nx_cfg_write = 1'b1;
                            nx_cfg_data = head.frames;
                            void'(pending_stim.pop_front());
                        end
                    end
                    default:
                    begin
                        if (!start && expected_outcomes.size() == 0)
                            void'(pending_stim.pop_front());
                    end
                endcase
            end
            start <= nx_start;
            page <= nx_page;
            cfg_write <= nx_cfg_write;
            cfg_data <= nx_cfg_data;
        end
    end

    function automatic int pick_gap(input bit quiet);
        int r;

        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_ref(input logic [PAGE_BITS-1:0] pg, input int gap);
        stim_t s;

        s.kind = STIM_REF;
        s.page = pg;
        s.frames = '0;
        s.gap = gap;
        pending_stim.push_back(s);
    endtask

    task automatic queue_cfg(input logic [CFG_W-1:0] frames, input stim_kind_t kind);
        stim_t s;

        s.kind = kind;
        s.page = '0;
        s.frames = frames;
        s.gap = 0;
        pending_stim.push_back(s);
    endtask

    initial
    begin
        int                   phase_frames[12];
        int                   n;
        int                   span;
        bit                   quiet;
        logic [PAGE_BITS-1:0] base;
        logic [PAGE_BITS-1:0] pg;

        phase_frames = '{16, 1, 0, 31, 5, 17, 2, 12, 8, 16, 0, 0};
        phase_frames[10] = $urandom_range(0, 31);
        phase_frames[11] = $urandom_range(1, 16);

        queue_ref(16'h0000, 0);
        queue_ref(16'hFFFF, 0);
        queue_ref(16'h0000, 2);
        queue_cfg(5'd2, STIM_CFG);
        queue_ref(16'h1234, 0);
        queue_ref(16'hFFFF, 0);
        queue_ref(16'h1234, 1);
        queue_cfg(5'd0, STIM_CFG);
        queue_ref(16'h1234, 0);
        queue_ref(16'h5555, 0);
        queue_ref(16'h5555, 0);
        queue_cfg(5'd31, STIM_CFG);
        queue_ref(16'hAAAA, 0);
        queue_ref(16'h1234, 0);
        queue_ref(16'h5555, 3);
        queue_cfg(5'd3, STIM_CFG);
        queue_ref(16'h0001, 0);
        queue_ref(16'h0002, 0);
        queue_ref(16'h1234, 0);
        queue_ref(16'h8000, 0);

        for (int ph = 0; ph < 12; ph++)
        begin
            queue_cfg(phase_frames[ph][CFG_W-1:0], STIM_CFG);
            n = active_frames(phase_frames[ph][CFG_W-1:0]);
            span = n + 2;
            base = PAGE_BITS'($urandom);
            quiet = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < 40; k++)
            begin
                if (k == 20 && ph % 3 == 1)
                    queue_cfg('0, STIM_DRAIN);
                if ($urandom_range(0, 9) < 7)
                    pg = base + PAGE_BITS'($urandom_range(0, span));
                else
                    pg = PAGE_BITS'($urandom);
                queue_ref(pg, pick_gap(quiet));
            end
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_stim.size() != 0 || start || expected_outcomes.size() != 0)
            @(negedge clk);
        repeat (FRAMES + 8) @(posedge clk);
        if (expected_outcomes.size() != 0)
        begin
            $error("%0d result beats never arrived", expected_outcomes.size());
            failures++;
        end
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_frame_mem.sv
rtl/core/lrupr_scan_unit.sv
rtl/core/lru_page_replacement.sv
tb/lru_page_replacement_tb.sv
